### rtl/dda_pkg.sv
package dda_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 4;
  localparam int STEP_FRAC_BITS  = 16;
  localparam int COORD_SHIFT     = STEP_FRAC_BITS - COORD_FRAC_BITS;

  // Screen extent used by the clamp
  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;

  // Field and state widths
  localparam int COORD_W  = 16;                        // endpoint fields
  localparam int MAG_W    = 16;                        // |end - start|
  localparam int QUO_W    = STEP_FRAC_BITS + 1;        // step magnitude, up to 1.0
  localparam int STEP_W   = QUO_W + 1;                 // signed step
  localparam int POS_W    = 30;                        // signed position
  localparam int LEFT_W   = MAG_W + 1 - COORD_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(STEP_FRAC_BITS + 1);
  localparam int PIX_W    = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 1'b1;

  localparam logic [CFG_W-1:0] X_OFFSET_RESET = 16'd8192;
  localparam logic [CFG_W-1:0] Y_OFFSET_RESET = 16'd9452;
  localparam logic [7:0]       ALPHA_OPAQUE   = 8'hFF;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             on_screen;
    logic [31:0]      pixel_colour;
    logic             last;
  } out_t;

endpackage

### rtl/dda_div.sv
module dda_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dda_pkg::MAG_W-1:0] num,
  input  logic [dda_pkg::MAG_W-1:0] den,
  output logic                      done,
  output logic [dda_pkg::QUO_W-1:0] quo
);
  import dda_pkg::*;

  // Restoring divider for (num << STEP_FRAC_BITS) / den with num <= den.
  // One quotient bit per cycle, MSB first.
  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MAG_W:0]       rem;
  logic [MAG_W+1:0]     trial;
  logic                 qbit;
  logic [MAG_W-1:0]     rem_keep;

  assign trial    = {1'b0, rem} - {2'b00, den};
  assign qbit     = ~trial[MAG_W+1];
  assign rem_keep = qbit ? trial[MAG_W-1:0] : rem[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      cnt <= DIV_CNT_W'(STEP_FRAC_BITS);
    end else if (busy) begin
      quo <= {quo[QUO_W-2:0], qbit};
      rem <= {rem_keep, 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

### rtl/dda_line_rasterizer.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    in_data  (op, endpoints, colour)
// out       out  out_valid / out_stall  out_data (pixel, on_screen, colour, last)
// cfg       in   wr_en                  wr_index, wr_data (screen offsets)
//
// Ticks stream one per cycle while the output register drains. A load of a
// zero-length line needs no divide; any other load holds in_stall after its
// transfer while the shared bit-serial divider runs once per axis, x then y:
// a start pulse, STEP_FRAC_BITS+1 quotient bits, then done handed back.
// rst is synchronous: offsets return to their defaults, the line goes idle.
// in_stall is high while dividing or while a pixel waits on a stalled output.
module dda_line_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dda_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dda_pkg::out_t                 out_data,
  input  logic                          wr_en,
  input  logic [dda_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [dda_pkg::CFG_W-1:0]     wr_data
);
  import dda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVX = 2'd1;
  localparam logic [1:0] ST_DIVY = 2'd2;

  localparam int W_W = POS_W + 2;                      // tick sum width
  localparam int R_W = W_W - 1 - STEP_FRAC_BITS;       // rounded magnitude
  localparam logic [R_W-1:0] X_MAX = R_W'(SCREEN_WIDTH - 1);
  localparam logic [R_W-1:0] Y_MAX = R_W'(SCREEN_HEIGHT - 1);
  localparam logic [W_W-1:0] HALF  = W_W'(1) << (STEP_FRAC_BITS - 1);

  logic [1:0]                state;
  logic [CFG_W-1:0]          x_off;
  logic [CFG_W-1:0]          y_off;
  logic signed [POS_W-1:0]   x_pos;
  logic signed [POS_W-1:0]   y_pos;
  logic signed [STEP_W-1:0]  x_step;
  logic signed [STEP_W-1:0]  y_step;
  logic [LEFT_W-1:0]         pixels_left;
  logic [23:0]               colour;
  logic                      line_active;
  logic [MAG_W-1:0]          ax;
  logic [MAG_W-1:0]          ay;
  logic [MAG_W-1:0]          span;
  logic                      x_neg;
  logic                      y_neg;
  logic                      div_start;
  logic                      div_done;
  logic [QUO_W-1:0]          div_quo;
  logic [STEP_W-1:0]         quo_ext;

  // Load-side arithmetic: deltas, magnitudes, major-axis span
  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W:0]          adx;
  logic [COORD_W:0]          ady;
  logic [MAG_W-1:0]          ax_in;
  logic [MAG_W-1:0]          ay_in;
  logic [MAG_W-1:0]          span_in;
  logic [MAG_W:0]            span_ceil;

  // Tick-side arithmetic: offset, round half away from zero, clamp
  logic signed [W_W-1:0]     wx;
  logic signed [W_W-1:0]     wy;
  logic                      wx_pos;
  logic                      wy_pos;
  logic [R_W-1:0]            rx;
  logic [R_W-1:0]            ry;
  logic                      x_ok;
  logic                      y_ok;
  logic [R_W-1:0]            cx;
  logic [R_W-1:0]            cy;

  logic in_xfer;
  logic do_load;
  logic do_tick;
  logic emit;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign do_load  = in_xfer && (in_data.op == OP_LOAD);
  assign do_tick  = in_xfer && (in_data.op == OP_TICK);
  assign emit     = do_tick && line_active && (pixels_left != '0);

  assign dx        = $signed({in_data.end_x[COORD_W-1], in_data.end_x})
                   - $signed({in_data.start_x[COORD_W-1], in_data.start_x});
  assign dy        = $signed({in_data.end_y[COORD_W-1], in_data.end_y})
                   - $signed({in_data.start_y[COORD_W-1], in_data.start_y});
  assign adx       = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
  assign ady       = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
  assign ax_in     = adx[MAG_W-1:0];
  assign ay_in     = ady[MAG_W-1:0];
  assign span_in   = (ax_in > ay_in) ? ax_in : ay_in;
  // ceil(span / 2^COORD_FRAC_BITS)
  assign span_ceil = {1'b0, span_in} + (MAG_W+1)'((1 << COORD_FRAC_BITS) - 1);

  // One divider shared by both axes: x first, then y
  dda_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ((state == ST_DIVY) ? ay : ax),
    .den   (span),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_ext = {1'b0, div_quo};

  // Offset carries COORD_FRAC_BITS fraction bits; align it to the position
  assign wx = W_W'(x_pos) + W_W'({x_off, {COORD_SHIFT{1'b0}}}) + HALF;
  assign wy = W_W'(y_pos) + W_W'({y_off, {COORD_SHIFT{1'b0}}}) + HALF;
  // With half added, floor of a positive sum is the rounded pixel;
  // a non-positive sum rounds below zero.
  assign wx_pos = !wx[W_W-1] && (wx != '0);
  assign wy_pos = !wy[W_W-1] && (wy != '0);
  assign rx     = wx[W_W-2:STEP_FRAC_BITS];
  assign ry     = wy[W_W-2:STEP_FRAC_BITS];
  assign x_ok   = wx_pos && (rx <= X_MAX);
  assign y_ok   = wy_pos && (ry <= Y_MAX);
  assign cx     = !wx_pos ? '0 : ((rx > X_MAX) ? X_MAX : rx);
  assign cy     = !wy_pos ? '0 : ((ry > Y_MAX) ? Y_MAX : ry);

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      x_off <= X_OFFSET_RESET;
      y_off <= Y_OFFSET_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_X_OFFSET: x_off <= wr_data;
        CFG_Y_OFFSET: y_off <= wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      div_start   <= 1'b0;
      line_active <= 1'b0;
      pixels_left <= '0;
      x_pos       <= '0;
      y_pos       <= '0;
      x_step      <= '0;
      y_step      <= '0;
      colour      <= '0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (do_load) begin
            x_pos <= {{(POS_W-COORD_W-COORD_SHIFT){in_data.start_x[COORD_W-1]}},
                      in_data.start_x, {COORD_SHIFT{1'b0}}};
            y_pos <= {{(POS_W-COORD_W-COORD_SHIFT){in_data.start_y[COORD_W-1]}},
                      in_data.start_y, {COORD_SHIFT{1'b0}}};
            colour      <= {in_data.red, in_data.green, in_data.blue};
            line_active <= 1'b1;
            if (span_in == '0) begin
              // zero-length line: one pixel at the start point
              x_step      <= '0;
              y_step      <= '0;
              pixels_left <= LEFT_W'(1);
            end else begin
              pixels_left <= span_ceil[MAG_W:COORD_FRAC_BITS];
              div_start   <= 1'b1;
              state       <= ST_DIVX;
            end
          end else if (do_tick) begin
            if (emit) begin
              x_pos       <= x_pos + POS_W'(x_step);
              y_pos       <= y_pos + POS_W'(y_step);
              pixels_left <= pixels_left - 1'b1;
              if (pixels_left == LEFT_W'(1)) begin
                line_active <= 1'b0;
              end
            end else begin
              line_active <= 1'b0;
            end
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            x_step    <= x_neg ? -$signed(quo_ext) : $signed(quo_ext);
            div_start <= 1'b1;
            state     <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            y_step <= y_neg ? -$signed(quo_ext) : $signed(quo_ext);
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Divider operands, held for the whole load
  always_ff @(posedge clk) begin
    if (do_load) begin
      ax    <= ax_in;
      ay    <= ay_in;
      span  <= span_in;
      x_neg <= dx[COORD_W];
      y_neg <= dy[COORD_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.pixel_x      <= cx[PIX_W-1:0];
      out_data.pixel_y      <= cy[PIX_W-1:0];
      out_data.on_screen    <= x_ok && y_ok;
      out_data.pixel_colour <= {ALPHA_OPAQUE, colour};
      out_data.last         <= (pixels_left == LEFT_W'(1));
    end
  end

endmodule
